>>> rtl/core/wdm_pkg.sv
package wdm_pkg;

    localparam int FIELD_W          = 32;
    localparam int DEF_MAX_SAMPLES  = 128;
    localparam int DEF_COORD_BITS   = 32;
    localparam int LANES            = 3;

    typedef struct packed {
        logic signed [FIELD_W-1:0] sample_x;
        logic signed [FIELD_W-1:0] sample_y;
        logic signed [FIELD_W-1:0] sample_z;
        logic                      sample_valid;
        logic                      last_sample;
    } t_sample;

    typedef struct packed {
        logic signed [FIELD_W-1:0] median_x;
        logic signed [FIELD_W-1:0] median_y;
        logic signed [FIELD_W-1:0] median_z;
        logic                      found;
    } t_result;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic take;     // input beat accepted
        logic setup;    // start selection
        logic scan;     // issue one store read
        logic decide;   // settle one key bit
        logic emit;     // load result register, empty the store
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic bit_zero;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/core/wdm_stream_if.sv
interface wdm_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/wdm_ctrl.sv
module wdm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    output logic          o_in_ready,
    input  wdm_pkg::t_stat i_stat,
    output wdm_pkg::t_cmd  o_cmd
);

    wdm_pkg::t_state r_state;
    wdm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wdm_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wdm_pkg::ST_LOAD: begin
                if (i_in_valid && i_in_last) n_state = wdm_pkg::ST_SETUP;
            end
            wdm_pkg::ST_SETUP: begin
                n_state = i_stat.count_zero ? wdm_pkg::ST_EMIT : wdm_pkg::ST_SCAN;
            end
            wdm_pkg::ST_SCAN: begin
                if (i_stat.scan_last) n_state = wdm_pkg::ST_DRAIN;
            end
            wdm_pkg::ST_DRAIN: begin
                n_state = wdm_pkg::ST_DECIDE;
            end
            wdm_pkg::ST_DECIDE: begin
                n_state = i_stat.bit_zero ? wdm_pkg::ST_EMIT : wdm_pkg::ST_SCAN;
            end
            wdm_pkg::ST_EMIT: begin
                if (i_stat.out_free) n_state = wdm_pkg::ST_LOAD;
            end
            default: begin
                n_state = wdm_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            wdm_pkg::ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            wdm_pkg::ST_SETUP:  o_cmd.setup  = 1'b1;
            wdm_pkg::ST_SCAN:   o_cmd.scan   = 1'b1;
            wdm_pkg::ST_DRAIN: begin
            end
            wdm_pkg::ST_DECIDE: o_cmd.decide = 1'b1;
            wdm_pkg::ST_EMIT:   o_cmd.emit   = i_stat.out_free;
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/core/wdm_datapath.sv
module wdm_datapath #(
    parameter int MAX_SAMPLES = wdm_pkg::DEF_MAX_SAMPLES,
    parameter int COORD_BITS  = wdm_pkg::DEF_COORD_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wdm_pkg::t_cmd    i_cmd,
    output wdm_pkg::t_stat   o_stat,
    input  wdm_pkg::t_sample i_sample,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output wdm_pkg::t_result o_result
);

    localparam int CB     = COORD_BITS;
    localparam int FW     = wdm_pkg::FIELD_W;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int BIT_W  = $clog2(CB);
    localparam logic [CB-1:0] SIGN_BIT = {1'b1, {(CB-1){1'b0}}};

    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_addr;
    logic              r_rd_vld;
    logic [BIT_W-1:0]  r_bit;
    logic [CB-1:0]     r_mask;
    logic              r_out_vld;
    wdm_pkg::t_result  r_out;

    logic              full;
    logic              wr_en;
    logic [CB-1:0]     bit_sel;
    logic [FW-1:0]     lane_in  [wdm_pkg::LANES];
    logic [FW-1:0]     lane_med [wdm_pkg::LANES];

    assign full    = (r_count == CNT_W'(MAX_SAMPLES));
    assign wr_en   = i_cmd.take && i_sample.sample_valid && !full;
    assign bit_sel = CB'(1) << r_bit;

    assign lane_in[0] = i_sample.sample_x;
    assign lane_in[1] = i_sample.sample_y;
    assign lane_in[2] = i_sample.sample_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_bit     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_count <= '0;
            end else if (wr_en) begin
                r_count <= r_count + CNT_W'(1);
            end

            if (i_cmd.setup || i_cmd.decide) begin
                r_addr <= '0;
            end else if (i_cmd.scan) begin
                r_addr <= r_addr + ADDR_W'(1);
            end
            r_rd_vld <= i_cmd.scan;

            if (i_cmd.setup) begin
                r_bit <= BIT_W'(CB - 1);
            end else if (i_cmd.decide) begin
                r_bit <= r_bit - BIT_W'(1);
            end

            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_mask <= '0;
        end else if (i_cmd.decide) begin
            r_mask <= r_mask | bit_sel;
        end
    end

    // One radix-select lane per coordinate. Each pass counts the stored keys
    // that share the settled upper bits and hold a zero at the current bit.
    for (genvar g = 0; g < wdm_pkg::LANES; g++) begin : g_lane
        logic [CB-1:0]    mem [MAX_SAMPLES];
        logic [CB-1:0]    w_in;
        logic [CB-1:0]    r_rd;
        logic [CB-1:0]    key;
        logic [CB-1:0]    r_prefix;
        logic [CNT_W-1:0] r_rank;
        logic [CNT_W-1:0] r_hits;
        logic             hit;
        logic [CB-1:0]    med_word;

        if (CB <= FW) begin : g_in_narrow
            assign w_in = lane_in[g][CB-1:0];
        end else begin : g_in_wide
            assign w_in = {{(CB-FW){1'b0}}, lane_in[g]};
        end

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                mem[r_count[ADDR_W-1:0]] <= w_in;
            end
            r_rd <= mem[r_addr];
        end

        assign key = r_rd ^ SIGN_BIT;
        assign hit = r_rd_vld && ((key & r_mask) == r_prefix) && !key[r_bit];

        always_ff @(posedge i_clk) begin
            if (i_cmd.setup || i_cmd.decide) begin
                r_hits <= '0;
            end else if (hit) begin
                r_hits <= r_hits + CNT_W'(1);
            end

            if (i_cmd.setup) begin
                r_prefix <= '0;
                r_rank   <= r_count >> 1;
            end else if (i_cmd.decide) begin
                if (r_rank >= r_hits) begin
                    r_prefix <= r_prefix | bit_sel;
                    r_rank   <= r_rank - r_hits;
                end
            end
        end

        assign med_word = r_prefix ^ SIGN_BIT;

        if (CB >= FW) begin : g_out_wide
            assign lane_med[g] = med_word[FW-1:0];
        end else begin : g_out_narrow
            assign lane_med[g] = {{(FW-CB){med_word[CB-1]}}, med_word};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.found    <= (r_count != '0);
            r_out.median_x <= (r_count != '0) ? lane_med[0] : '0;
            r_out.median_y <= (r_count != '0) ? lane_med[1] : '0;
            r_out.median_z <= (r_count != '0) ? lane_med[2] : '0;
        end
    end

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.scan_last  = (CNT_W'(r_addr) == (r_count - CNT_W'(1)));
    assign o_stat.bit_zero   = (r_bit == '0);
    assign o_stat.out_free   = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

endmodule

>>> rtl/core/window_depth_median_top.sv
// Robust 3-D position of one detected box. Sample beats stream in one per cycle
// while the block is loading; valid ones are written to three coordinate stores
// (up to MAX_SAMPLES, extra valid samples are dropped). The beat flagged
// last_sample starts a bitwise radix select of the upper median (rank count/2,
// signed order) run in parallel for x, y and z: per key bit, one pass reads all
// n stored samples through the single read port of each store, then come a drain
// step and a decide step; when no sample was valid the select is skipped. Input
// is blocked from the last beat until the result is emitted. One result beat
// follows every last sample; found is 0 and the medians are 0 when no sample of
// the box was valid. The result sits in an output register and may wait there
// while the next box loads; a box that finishes while it still waits holds off
// until the register frees.
module window_depth_median_top #(
    parameter int MAX_SAMPLES = wdm_pkg::DEF_MAX_SAMPLES,
    parameter int COORD_BITS  = wdm_pkg::DEF_COORD_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wdm_stream_if.sink   i_sample,
    wdm_stream_if.source o_result
);

    wdm_pkg::t_cmd  cmd;
    wdm_pkg::t_stat stat;

    wdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .i_in_last  (i_sample.data.last_sample),
        .o_in_ready (i_sample.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wdm_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_sample    (i_sample.data),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_result    (o_result.data)
    );

    // the sequencer drives at most one command per cycle
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.take, cmd.setup, cmd.scan, cmd.decide, cmd.emit}))
        else $error("overlapping datapath commands");

    // a last beat closes the box: input stalls while the median is selected
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready && i_sample.data.last_sample)
        |=> !i_sample.ready)
        else $error("input taken during selection");

    // an empty box reports zero medians
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.data.found) |->
        (o_result.data.median_x == '0 && o_result.data.median_y == '0 &&
         o_result.data.median_z == '0))
        else $error("nonzero median without valid samples");

    // every result beat follows an emit command
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(cmd.emit))
        else $error("result without emit");

endmodule
